[design/weighted_quota_allocator_macros.svh]
// Assertion macros for the weighted quota allocator RTL.
`ifndef WEIGHTED_QUOTA_ALLOCATOR_MACROS_SVH
`define WEIGHTED_QUOTA_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WQA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WQA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/wqa_pkg.sv]
// Package with widths, constants and types of the weighted quota allocator.
package wqa_pkg;

   localparam int MAX_WEIGHTS  = 64;
   localparam int IDX_W        = $clog2(MAX_WEIGHTS);
   localparam int CNT_W        = $clog2(MAX_WEIGHTS + 1);
   localparam int WEIGHT_W     = 32;
   localparam int QUOTA_W      = 16;
   localparam int SUM_W        = WEIGHT_W + CNT_W;          // signed running sum
   localparam int SSUM_W       = SUM_W - 1;                 // shifted sum, non-negative
   localparam int NUM_W        = QUOTA_W + WEIGHT_W;        // total * (w - min)
   localparam int DIVIDEND_W   = NUM_W + 1;                 // num + S - 1
   localparam int DVS_W        = SSUM_W + QUOTA_W - 1;      // divisor aligned to top bit
   localparam int STEP_W       = $clog2(QUOTA_W);

   localparam logic signed [WEIGHT_W-1:0] MIN_RESET = {1'b0, {(WEIGHT_W-1){1'b1}}};

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SUM,
      ST_READ,
      ST_MUL,
      ST_START,
      ST_DIVIDE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               done;
      logic [QUOTA_W-1:0] quotient;
   } div_status_type;

endpackage

[design/wqa_channels.sv]
// Valid/ready channel interfaces for weights in and quotas out.
interface wqa_req_if;
   import wqa_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [WEIGHT_W-1:0] weight;
   logic                       last_weight;

   modport source (output valid, output weight, output last_weight, input ready);
   modport sink   (input valid, input weight, input last_weight, output ready);
endinterface

interface wqa_rsp_if;
   import wqa_pkg::*;

   logic               valid;
   logic               ready;
   logic [QUOTA_W-1:0] quota;
   logic [IDX_W-1:0]   weight_index;
   logic               last_quota;
   logic               zero_sum;
   logic               overflowed;

   modport source (output valid, output quota, output weight_index, output last_quota,
                   output zero_sum, output overflowed, input ready);
   modport sink   (input valid, input quota, input weight_index, input last_quota,
                   input zero_sum, input overflowed, output ready);
endinterface

[design/wqa_divider.sv]
// Restoring divider, one quotient bit per cycle, for quota = (num + S - 1) / S.
module wqa_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [wqa_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [wqa_pkg::SSUM_W-1:0]         divisor,
   output wqa_pkg::div_status_type            status
);
   import wqa_pkg::*;

   logic [DVS_W-1:0]   rem_ff,  rem_in;
   logic [DVS_W-1:0]   dvs_ff,  dvs_in;
   logic [QUOTA_W-1:0] quo_ff,  quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               fits;

   // one compare-subtract step
   assign fits = (rem_ff >= dvs_ff);

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = DVS_W'(dividend);
         dvs_in  = {divisor, {(QUOTA_W-1){1'b0}}};
         quo_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         quo_in  = {quo_ff[QUOTA_W-2:0], fits};
         dvs_in  = dvs_ff >> 1;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(QUOTA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath flops
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

[design/weighted_quota_allocator.sv]
// Weighted quota allocator: loads signed weights, then emits one ceiling quota per weight.
//
// Weights are taken one per cycle into a 64-entry weight memory while the block
// tracks the minimum and the running sum; the transfer carrying last_weight ends
// the list (weights past 64 are dropped and reported through overflowed). Once
// S = sum(w - min) is formed, each quota passes through a memory read, a 16x32
// multiply, a divider load, 16 steps of the restoring divider (skipped when S is
// 0) and the handoff to the output register. No weights are taken while quotas
// are being computed; the next list may start once the final quota sits in the
// output register. When all weights are equal every quota is 0 with zero_sum set.
// The user must write total_samples through csr_ only while the block is idle;
// the block itself does not enforce this.
module weighted_quota_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [wqa_pkg::QUOTA_W-1:0] csr_write_data,
   wqa_req_if.sink                     req_chan,
   wqa_rsp_if.source                   rsp_chan
);
   import wqa_pkg::*;
   `include "weighted_quota_allocator_macros.svh"

   state_type                 state_ff, state_in;
   logic [QUOTA_W-1:0]        total_ff;
   logic signed [WEIGHT_W-1:0] min_ff;
   logic signed [SUM_W-1:0]   raw_sum_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      ovf_ff;
   logic [SSUM_W-1:0]         ssum_ff;
   logic                      zero_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [WEIGHT_W-1:0]       rd_data_ff;
   logic [NUM_W-1:0]          num_ff;

   logic [WEIGHT_W-1:0]       weight_mem [MAX_WEIGHTS];

   // output register
   logic                      rsp_valid_ff;
   logic [QUOTA_W-1:0]        quota_out_ff;
   logic [IDX_W-1:0]          index_out_ff;
   logic                      last_out_ff;
   logic                      zero_out_ff;
   logic                      ovf_out_ff;

   logic                      req_xfer, store_ok, is_last_idx;
   logic                      req_ready, rd_en, div_start, out_load;
   logic signed [SUM_W-1:0]   cnt_min, ssum_full;
   logic signed [WEIGHT_W:0]  diff_full;
   logic [DIVIDEND_W-1:0]     dividend;
   div_status_type            div_status;

   assign req_xfer    = req_chan.valid && req_ready;
   assign store_ok    = (count_ff < CNT_W'(MAX_WEIGHTS));
   assign is_last_idx = ((CNT_W'(idx_ff) + 1'b1) == count_ff);

   // shifted sum S = raw_sum - n * min
   assign cnt_min   = SUM_W'($signed({1'b0, count_ff})) * SUM_W'(min_ff);
   assign ssum_full = raw_sum_ff - cnt_min;

   // w - min, always non-negative and below 2^32
   assign diff_full = (WEIGHT_W+1)'(signed'(rd_data_ff)) - (WEIGHT_W+1)'(min_ff);

   // ceiling division by adding S - 1
   assign dividend = DIVIDEND_W'(num_ff) + DIVIDEND_W'(ssum_ff) - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer && req_chan.last_weight) state_in = ST_SUM;
         end
         ST_SUM:    state_in = ST_READ;
         ST_READ:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_START;
         ST_START:  state_in = zero_ff ? ST_OUT : ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_status.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = is_last_idx ? ST_LOAD : ST_READ;
            end
         end
         default:   state_in = ST_LOAD;
      endcase
   end

   // state decodes
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_LOAD:   req_ready = 1'b1;
         ST_READ:   rd_en     = 1'b1;
         ST_START:  div_start = !zero_ff;
         ST_OUT:    out_load  = !rsp_valid_ff || rsp_chan.ready;
         default:   ;
      endcase
   end

   assign req_chan.ready = req_ready;

   // state and list control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         total_ff   <= '0;
         min_ff     <= MIN_RESET;
         raw_sum_ff <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) total_ff <= csr_write_data;
         if (req_xfer) begin
            if (store_ok) begin
               if (req_chan.weight < min_ff) min_ff <= req_chan.weight;
               raw_sum_ff <= raw_sum_ff + SUM_W'(req_chan.weight);
               count_ff   <= count_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (out_load) begin
            if (is_last_idx) begin
               min_ff     <= MIN_RESET;
               raw_sum_ff <= '0;
               count_ff   <= '0;
               ovf_ff     <= 1'b0;
               idx_ff     <= '0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   // weight memory write
   always_ff @(posedge clock) begin
      if (req_xfer && store_ok) weight_mem[count_ff[IDX_W-1:0]] <= req_chan.weight;
   end

   // weight memory read, registered
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= weight_mem[idx_ff];
   end

   // per-list and per-quota datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         ssum_ff <= ssum_full[SSUM_W-1:0];
         zero_ff <= (ssum_full == '0);
      end
      if (state_ff == ST_MUL) num_ff <= NUM_W'(total_ff) * NUM_W'(diff_full[WEIGHT_W-1:0]);
   end

   wqa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (ssum_ff),
      .status   (div_status)
   );

   // result register: valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register: payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         quota_out_ff <= zero_ff ? '0 : div_status.quotient;
         index_out_ff <= idx_ff;
         last_out_ff  <= is_last_idx;
         zero_out_ff  <= zero_ff;
         ovf_out_ff   <= ovf_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.quota        = quota_out_ff;
   assign rsp_chan.weight_index = index_out_ff;
   assign rsp_chan.last_quota   = last_out_ff;
   assign rsp_chan.zero_sum     = zero_out_ff;
   assign rsp_chan.overflowed   = ovf_out_ff;

   // checks
   `WQA_ASSERT_NEXT(a_list_cleared, clock, reset, out_load && is_last_idx,
      count_ff == '0 && ovf_ff == 1'b0 && raw_sum_ff == '0, "list state not cleared")
   `WQA_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(MAX_WEIGHTS), "item count beyond capacity")
   `WQA_ASSERT_IMPL(a_zero_quota, clock, reset, rsp_valid_ff && zero_out_ff,
      quota_out_ff == '0, "nonzero quota with zero sum")
   `WQA_ASSERT_IMPL(a_quota_bound, clock, reset, rsp_valid_ff,
      quota_out_ff <= total_ff, "quota exceeds total samples")
   `WQA_ASSERT_IMPL(a_div_done_state, clock, reset, div_status.done,
      state_ff == ST_DIVIDE, "divider finished outside divide state")

endmodule
